// File: rtl/blbm_pkg.sv
// Shared types and constants for the battery level band monitor.
// No dependencies; imported by battery_level_band_monitor_unit and the testbench.
package blbm_pkg;

    localparam int VOLTAGE_BITS_DEF = 13;

    // configuration register indexes
    localparam int          CFG_INDEX_BITS     = 3;
    localparam logic [2:0]  REG_EMPTY          = 3'd0;
    localparam logic [2:0]  REG_FULL           = 3'd1;
    localparam logic [2:0]  REG_DISCONNECT     = 3'd2;
    localparam logic [2:0]  REG_RECOVERY       = 3'd3;
    localparam logic [2:0]  REG_MIN_RISE       = 3'd4;
    localparam logic [2:0]  REG_CHARGE_STREAK  = 3'd5;
    localparam logic [2:0]  REG_ABSENT_STREAK  = 3'd6;

    // register reset values
    localparam int          EMPTY_MV_RST       = 3100;
    localparam int          FULL_MV_RST        = 4200;
    localparam int          DISCONNECT_MV_RST  = 1800;
    localparam int          RECOVERY_MV_RST    = 2500;
    localparam logic [7:0]  MIN_RISE_RST       = 8'd20;
    localparam logic [7:0]  CHARGE_STREAK_RST  = 8'd3;
    localparam logic [7:0]  ABSENT_STREAK_RST  = 8'd5;

    localparam logic [7:0]  COUNT_MAX          = 8'd255;

    // percentage and divider
    localparam int          PCT_BITS           = 7;
    localparam int          STEP_BITS          = 3;
    localparam int          PCT_SCALE          = 200;
    localparam logic [6:0]  PCT_FULL           = 7'd100;
    localparam logic [6:0]  PCT_ZERO           = 7'd0;
    localparam logic [6:0]  PCT_80             = 7'd80;
    localparam logic [6:0]  PCT_60             = 7'd60;
    localparam logic [6:0]  PCT_40             = 7'd40;
    localparam logic [6:0]  PCT_20             = 7'd20;
    localparam logic [6:0]  PCT_10             = 7'd10;

    // band codes
    localparam logic [2:0]  BAND_ABSENT        = 3'd0;
    localparam logic [2:0]  BAND_CHARGING      = 3'd1;
    localparam logic [2:0]  BAND_80_100        = 3'd2;
    localparam logic [2:0]  BAND_60_79         = 3'd3;
    localparam logic [2:0]  BAND_40_59         = 3'd4;
    localparam logic [2:0]  BAND_20_39         = 3'd5;
    localparam logic [2:0]  BAND_10_19         = 3'd6;
    localparam logic [2:0]  BAND_UNDER_10      = 3'd7;

endpackage

// File: rtl/battery_level_band_monitor_unit.sv
// Battery level band monitor: percentage, absence/charging detection, band flags.
// Depends on blbm_pkg for constants and register indexes.
//
// One request per voltage sample produces one result. A request passes from
// acceptance through a setup state, seven restoring-division steps on a single
// shared subtract/compare unit (one percentage bit per step), and a finish state
// that updates the streak counters and band; the next request is accepted only
// after that. When full_mv is not above empty_mv the divider is skipped. The
// result sits in an output register, so the next request is taken while a
// finished result still waits for out_ready.
// Configuration writes are always ready and must only be issued while idle.
module battery_level_band_monitor_unit
    import blbm_pkg::*;
#(
    parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VOLTAGE_BITS-1:0]   cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [VOLTAGE_BITS-1:0]   voltage_mv,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                band,
    output logic [PCT_BITS-1:0]       percent,
    output logic                      charging,
    output logic                      band_changed,
    output logic                      absent_confirmed
);

    localparam int NUM_BITS = VOLTAGE_BITS + 9;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PCT_BITS - 1);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FIN} state_t;

    state_t                  state_reg, state_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;

    // configuration
    logic [VOLTAGE_BITS-1:0] empty_reg, full_reg, disconnect_reg, recovery_reg;
    logic [7:0]              min_rise_reg, charge_need_reg, absent_need_reg;

    // per-sample history
    logic [VOLTAGE_BITS-1:0] prev_reg;
    logic [7:0]              rise_reg, rise_next;
    logic [7:0]              low_reg, low_next;
    logic                    absent_reg, absent_next;
    logic [2:0]              cur_band_reg, band_next;
    logic                    band_valid_reg;

    // output register
    logic                    out_valid_reg;
    logic [2:0]              band_out_reg;
    logic [PCT_BITS-1:0]     pct_out_reg;
    logic                    chg_out_reg, changed_out_reg, absent_out_reg;

    // divider datapath
    logic [VOLTAGE_BITS-1:0] v_reg;
    logic [NUM_BITS-1:0]     rem_reg, rem_next;
    logic [NUM_BITS-1:0]     dsr_reg, dsr_next;
    logic [PCT_BITS-1:0]     quo_reg, quo_next;

    logic                    accept, fire, degenerate, is_low, rise_hit, chg, changed, ge;
    logic [VOLTAGE_BITS-1:0] span, clamped, c_val;
    logic [VOLTAGE_BITS:0]   rise_limit;

    assign accept = in_valid && in_ready;
    assign fire   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // setup values for the divider
    assign degenerate = (full_reg <= empty_reg);
    assign span       = full_reg - empty_reg;
    always_comb
    begin
        if (v_reg < empty_reg)
            clamped = empty_reg;
        else if (v_reg > full_reg)
            clamped = full_reg;
        else
            clamped = v_reg;
    end
    assign c_val = clamped - empty_reg;

    // shared compare/subtract unit
    assign ge = (rem_reg >= dsr_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                step_next = '0;
                quo_next  = '0;
                // numerator 200*c + span, divisor 2*span aligned to the top quotient bit
                rem_next  = NUM_BITS'(c_val) * NUM_BITS'(PCT_SCALE) + NUM_BITS'(span);
                dsr_next  = NUM_BITS'({span, 1'b0}) << (PCT_BITS - 1);
                if (degenerate)
                begin
                    quo_next   = (v_reg >= empty_reg) ? PCT_FULL : PCT_ZERO;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ge)
                    rem_next = rem_reg - dsr_reg;
                quo_next  = {quo_reg[PCT_BITS-2:0], ge};
                dsr_next  = dsr_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // streak counters and band selection for the finishing sample
    assign is_low     = (v_reg < disconnect_reg);
    assign rise_limit = {1'b0, prev_reg} + (VOLTAGE_BITS + 1)'(min_rise_reg);
    assign rise_hit   = (prev_reg != '0) && ({1'b0, v_reg} >= rise_limit);

    always_comb
    begin
        if (is_low)
        begin
            low_next    = (low_reg == COUNT_MAX) ? low_reg : low_reg + 8'd1;
            absent_next = absent_reg || (low_next >= absent_need_reg);
        end
        else
        begin
            low_next    = '0;
            absent_next = (v_reg >= recovery_reg) ? 1'b0 : absent_reg;
        end

        if (rise_hit)
            rise_next = (rise_reg == COUNT_MAX) ? rise_reg : rise_reg + 8'd1;
        else
            rise_next = '0;
    end

    assign chg = (rise_next >= charge_need_reg);

    always_comb
    begin
        priority if (absent_next ? (v_reg < recovery_reg) : is_low)
            band_next = BAND_ABSENT;
        else if (chg)
            band_next = BAND_CHARGING;
        else if (quo_reg >= PCT_80)
            band_next = BAND_80_100;
        else if (quo_reg >= PCT_60)
            band_next = BAND_60_79;
        else if (quo_reg >= PCT_40)
            band_next = BAND_40_59;
        else if (quo_reg >= PCT_20)
            band_next = BAND_20_39;
        else if (quo_reg >= PCT_10)
            band_next = BAND_10_19;
        else
            band_next = BAND_UNDER_10;
    end

    assign changed = band_valid_reg && (band_next != cur_band_reg);

    // control, history, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            empty_reg       <= VOLTAGE_BITS'(EMPTY_MV_RST);
            full_reg        <= VOLTAGE_BITS'(FULL_MV_RST);
            disconnect_reg  <= VOLTAGE_BITS'(DISCONNECT_MV_RST);
            recovery_reg    <= VOLTAGE_BITS'(RECOVERY_MV_RST);
            min_rise_reg    <= MIN_RISE_RST;
            charge_need_reg <= CHARGE_STREAK_RST;
            absent_need_reg <= ABSENT_STREAK_RST;
            prev_reg        <= '0;
            rise_reg        <= '0;
            low_reg         <= '0;
            absent_reg      <= 1'b0;
            cur_band_reg    <= BAND_80_100;
            band_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            band_out_reg    <= BAND_80_100;
            pct_out_reg     <= '0;
            chg_out_reg     <= 1'b0;
            changed_out_reg <= 1'b0;
            absent_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_EMPTY:         empty_reg       <= cfg_data;
                    REG_FULL:          full_reg        <= cfg_data;
                    REG_DISCONNECT:    disconnect_reg  <= cfg_data;
                    REG_RECOVERY:      recovery_reg    <= cfg_data;
                    REG_MIN_RISE:      min_rise_reg    <= cfg_data[7:0];
                    REG_CHARGE_STREAK: charge_need_reg <= cfg_data[7:0];
                    REG_ABSENT_STREAK: absent_need_reg <= cfg_data[7:0];
                    default:           ;
                endcase
            end

            if (fire)
            begin
                prev_reg        <= v_reg;
                rise_reg        <= rise_next;
                low_reg         <= low_next;
                absent_reg      <= absent_next;
                cur_band_reg    <= band_next;
                band_valid_reg  <= 1'b1;
                out_valid_reg   <= 1'b1;
                band_out_reg    <= band_next;
                pct_out_reg     <= quo_reg;
                chg_out_reg     <= chg;
                changed_out_reg <= changed;
                absent_out_reg  <= absent_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (accept)
            v_reg <= voltage_mv;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign cfg_ready        = 1'b1;
    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign band             = band_out_reg;
    assign percent          = pct_out_reg;
    assign charging         = chg_out_reg;
    assign band_changed     = changed_out_reg;
    assign absent_confirmed = absent_out_reg;

    // an accepted request blocks the input until the result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input ready while a request is in progress");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent <= PCT_FULL))
        else $error("percent above 100");

    a_charging_band: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && charging && band != BAND_ABSENT) |-> (band == BAND_CHARGING))
        else $error("charging result not in charging band");

    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_FIN))
        else $error("result loaded outside finish state");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == LAST_STEP) |=> (state_reg == S_FIN))
        else $error("divider did not finish after last step");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for battery_level_band_monitor_unit: directed and random voltage
// samples under random handshake gaps, every result checked field by field.
// Depends on blbm_pkg and battery_level_band_monitor_unit.
module testbench;
    import blbm_pkg::*;

    localparam int VBITS = VOLTAGE_BITS_DEF;
    localparam int VMAX = (1 << VBITS) - 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_SAMPLES = 125;

    typedef struct packed {
        logic [2:0]          band;
        logic [PCT_BITS-1:0] percent;
        logic                charging;
        logic                changed;
        logic                absent;
    } reading_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [VBITS-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [VBITS-1:0]          voltage_mv = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [2:0]                band;
    logic [PCT_BITS-1:0]       percent;
    logic                      charging;
    logic                      band_changed;
    logic                      absent_confirmed;

    // predictor copy of the registers and the monitor state
    logic [VBITS-1:0] empty_lvl, full_lvl, cutoff_lvl, recover_lvl, last_mv;
    logic [7:0]       rise_step, charge_need, absent_need, rise_run, low_run;
    logic             absent_st, band_seen;
    logic [2:0]       last_band;

    reading_t pending_readings[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       samples_sent = 0;
    bit       gaps_on = 1'b1;
    bit       stalls_on = 1'b1;
    int       stall_left = 0;

    battery_level_band_monitor_unit #(.VOLTAGE_BITS(VBITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .voltage_mv(voltage_mv),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .band(band),
        .percent(percent),
        .charging(charging),
        .band_changed(band_changed),
        .absent_confirmed(absent_confirmed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [VBITS-1:0] clip_mv(input int x);
        if (x < 0)
            return '0;
        if (x > VMAX)
            return VBITS'(VMAX);
        return VBITS'(x);
    endfunction

    function automatic logic [VBITS-1:0] pad_byte(input int b);
        logic [VBITS-1:0] w;
        w = VBITS'($urandom);
        w[7:0] = 8'(b);
        return w;
    endfunction

    // round-half-up of 100*(v-lo)/(hi-lo), v clamped into [lo, hi]
    function automatic logic [PCT_BITS-1:0] scale_percent(input int v, input int lo,
                                                           input int hi);
        int span, c;
        if (hi <= lo)
            return (v >= lo) ? PCT_FULL : PCT_ZERO;
        span = hi - lo;
        c = (v < lo) ? lo : ((v > hi) ? hi : v);
        c = c - lo;
        return PCT_BITS'((PCT_SCALE * c + span) / (2 * span));
    endfunction

    function automatic logic [2:0] classify(input logic [PCT_BITS-1:0] pct, input logic chg,
                                            input int v);
        if (absent_st ? (v < recover_lvl) : (v < cutoff_lvl))
            return BAND_ABSENT;
        if (chg)
            return BAND_CHARGING;
        if (pct >= PCT_80)
            return BAND_80_100;
        if (pct >= PCT_60)
            return BAND_60_79;
        if (pct >= PCT_40)
            return BAND_40_59;
        if (pct >= PCT_20)
            return BAND_20_39;
        if (pct >= PCT_10)
            return BAND_10_19;
        return BAND_UNDER_10;
    endfunction

    function automatic reading_t predict_reading(input logic [VBITS-1:0] v);
        reading_t r;
        logic [PCT_BITS-1:0] pct;
        pct = scale_percent(int'(v), int'(empty_lvl), int'(full_lvl));
        if (v < cutoff_lvl)
        begin
            if (low_run != COUNT_MAX)
                low_run = low_run + 8'd1;
            if (low_run >= absent_need)
                absent_st = 1'b1;
        end
        else
        begin
            low_run = '0;
            if (v >= recover_lvl)
                absent_st = 1'b0;
        end
        // no wrap: the sum is taken at int width
        if (last_mv != '0 && int'(v) >= int'(last_mv) + int'(rise_step))
        begin
            if (rise_run != COUNT_MAX)
                rise_run = rise_run + 8'd1;
        end
        else
            rise_run = '0;
        r.charging = (rise_run >= charge_need);
        r.band = classify(pct, r.charging, int'(v));
        r.changed = band_seen && (r.band != last_band);
        r.percent = pct;
        r.absent = absent_st;
        last_band = r.band;
        band_seen = 1'b1;
        last_mv = v;
        return r;
    endfunction

    task automatic reset_model();
        empty_lvl = VBITS'(EMPTY_MV_RST);
        full_lvl = VBITS'(FULL_MV_RST);
        cutoff_lvl = VBITS'(DISCONNECT_MV_RST);
        recover_lvl = VBITS'(RECOVERY_MV_RST);
        rise_step = MIN_RISE_RST;
        charge_need = CHARGE_STREAK_RST;
        absent_need = ABSENT_STREAK_RST;
        last_mv = '0;
        rise_run = '0;
        low_run = '0;
        absent_st = 1'b0;
        last_band = BAND_80_100;
        band_seen = 1'b0;
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_reading();
        reading_t want;
        if (pending_readings.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual band %0d percent %0d",
                     $time, band, percent);
            mismatches++;
            return;
        end
        want = pending_readings.pop_front();
        compare_field("band", 8'(want.band), 8'(band));
        compare_field("percent", 8'(want.percent), 8'(percent));
        compare_field("charging", 8'(want.charging), 8'(charging));
        compare_field("band_changed", 8'(want.changed), 8'(band_changed));
        compare_field("absent_confirmed", 8'(want.absent), 8'(absent_confirmed));
    endfunction

    // result side: out_ready may drop for a random stall after each accepted result
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_reading();
            draw = stalls_on ? $urandom_range(3, 0) : 0;
            stall_left <= draw;
            out_ready <= (draw == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_sample(input logic [VBITS-1:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(3, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        voltage_mv <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_readings.push_back(predict_reading(v));
        samples_sent++;
    endtask

    // wait until every request has produced its result and the unit is idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [VBITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_EMPTY:         empty_lvl = data;
            REG_FULL:          full_lvl = data;
            REG_DISCONNECT:    cutoff_lvl = data;
            REG_RECOVERY:      recover_lvl = data;
            REG_MIN_RISE:      rise_step = data[7:0];
            REG_CHARGE_STREAK: charge_need = data[7:0];
            REG_ABSENT_STREAK: absent_need = data[7:0];
            default:           ;
        endcase
    endtask

    // 8-bit registers get random upper data bits, which must be dropped
    task automatic load_config(input int e, input int f, input int d, input int r,
                               input int rs, input int cs, input int as);
        settle();
        put_reg(REG_EMPTY, clip_mv(e));
        put_reg(REG_FULL, clip_mv(f));
        put_reg(REG_DISCONNECT, clip_mv(d));
        put_reg(REG_RECOVERY, clip_mv(r));
        put_reg(REG_MIN_RISE, pad_byte(rs));
        put_reg(REG_CHARGE_STREAK, pad_byte(cs));
        put_reg(REG_ABSENT_STREAK, pad_byte(as));
        put_reg(REG_SPARE, VBITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // first sample after reset must not flag a band change
    task automatic test_first_sample();
        send_sample(VBITS'(FULL_MV_RST));
        send_sample(VBITS'(VMAX));
        send_sample(VBITS'(EMPTY_MV_RST));
        send_sample('0);
    endtask

    task automatic test_percent_rounding();
        int offs[10] = '{0, 1, 19, 20, 39, 40, 79, 80, 160, 200};
        load_config(1000, 1200, 500, 600, 255, 255, 255);
        foreach (offs[i])
            send_sample(clip_mv(1000 + offs[i]));
    endtask

    // full equal to empty: percent is all or nothing
    task automatic test_flat_span();
        load_config(3000, 3000, 100, 200, 20, 3, 5);
        send_sample(VBITS'(2999));
        send_sample(VBITS'(3000));
        send_sample(VBITS'(VMAX));
    endtask

    task automatic test_zero_streaks();
        load_config(3100, 4200, 1800, 2500, 20, 0, 0);
        send_sample(VBITS'(1000));
        send_sample(VBITS'(2000));
        send_sample(VBITS'(4000));
    endtask

    // confirmed absence holds until the recovery level, not the disconnect level
    task automatic test_absence_recovery();
        load_config(3100, 4200, 1800, 2500, 20, 3, 2);
        send_sample(VBITS'(1799));
        send_sample(VBITS'(1799));
        send_sample(VBITS'(2499));
        send_sample(VBITS'(2500));
    endtask

    task automatic test_count_saturation();
        int v;
        load_config(100, 8000, 50, 60, 0, 255, 255);
        v = 200;
        repeat (270)
        begin
            v = v + $urandom_range(25, 0);
            send_sample(clip_mv(v));
        end
        repeat (270)
            send_sample(clip_mv($urandom_range(49, 1)));
        send_sample(VBITS'(VMAX));
    endtask

    task automatic random_config(input int phase);
        int e, f, d, r;
        case (phase)
            0: load_config(EMPTY_MV_RST, FULL_MV_RST, DISCONNECT_MV_RST, RECOVERY_MV_RST,
                           20, 3, 5);
            1: load_config(0, 0, 0, 0, 0, 0, 0);
            2: load_config(VMAX, VMAX, VMAX, VMAX, 255, 255, 255);
            3:
            begin
                e = $urandom_range(VMAX - 1, 0);
                load_config(e, e + 1, $urandom_range(3000, 1), $urandom_range(4000, 1),
                            $urandom_range(40, 0), $urandom_range(4, 1),
                            $urandom_range(4, 1));
            end
            default:
            begin
                e = $urandom_range(6000, 0);
                f = ($urandom_range(5, 0) == 0) ? $urandom_range(e, 0)
                                                  : e + $urandom_range(2000, 1);
                d = $urandom_range(3000, 0);
                r = ($urandom_range(4, 0) == 0) ? $urandom_range(d, 0)
                                                  : d + $urandom_range(1500, 0);
                load_config(e, f, d, r,
                            ($urandom_range(7, 0) == 0) ? 255 : $urandom_range(80, 0),
                            $urandom_range(8, 0),
                            ($urandom_range(7, 0) == 0) ? 255 : $urandom_range(8, 0));
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int phase, stop_at, kind, n, v, step, base;
        for (phase = 0; phase < 10; phase++)
        begin
            random_config(phase);
            stop_at = samples_sent + PHASE_SAMPLES;
            while (samples_sent < stop_at)
            begin
                gaps_on = ($urandom_range(3, 0) != 0);
                stalls_on = ($urandom_range(3, 0) != 0);
                kind = $urandom_range(9, 0);
                if (kind >= 3 && kind <= 4 && cutoff_lvl == '0)
                    kind = 9;
                if (kind <= 2)
                begin
                    // rising run toward charging, sometimes broken by a short step
                    v = $urandom_range(VMAX, 0);
                    n = $urandom_range(12, 2);
                    repeat (n)
                    begin
                        step = int'(rise_step) + $urandom_range(30, 0);
                        if ($urandom_range(7, 0) == 0)
                            step = int'(rise_step) - 1;
                        v = int'(clip_mv(v + step));
                        send_sample(clip_mv(v));
                    end
                end
                else if (kind <= 4)
                begin
                    // dropout, then up to two samples between the thresholds, then recovery
                    n = $urandom_range(int'(absent_need) + 3, 1);
                    if (n > 20)
                        n = 20;
                    repeat (n)
                        send_sample(clip_mv($urandom_range(int'(cutoff_lvl) - 1, 0)));
                    if (recover_lvl > cutoff_lvl)
                        repeat ($urandom_range(2, 0))
                            send_sample(clip_mv($urandom_range(int'(recover_lvl) - 1,
                                                               int'(cutoff_lvl))));
                    send_sample(clip_mv($urandom_range(VMAX, int'(recover_lvl))));
                end
                else if (kind <= 6)
                begin
                    case ($urandom_range(3, 0))
                        0: base = int'(empty_lvl);
                        1: base = int'(full_lvl);
                        2: base = int'(cutoff_lvl);
                        default: base = int'(recover_lvl);
                    endcase
                    repeat ($urandom_range(4, 1))
                        send_sample(clip_mv(base + $urandom_range(6, 0) - 3));
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                        send_sample(VBITS'($urandom_range(VMAX, 0)));
                end
            end
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_first_sample();
        test_percent_rounding();
        test_flat_span();
        test_zero_streaks();
        test_absence_recovery();
        test_count_saturation();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
